[hdl/ctl_pkg.sv]
// Package for the chunk tag locator: phase codes, register indexes
// and header constants. No dependencies.
`default_nettype none

package ctl_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_IDX_BITS    = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WANTED_TAG   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_OFFSET = 1'b1;

  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_Z   = 8'h5A;
  localparam logic [7:0] CHAR_TWO = 8'h32;

  // Header: four tag bytes, then four size bytes.
  localparam logic [3:0] HDR_TAG_BYTES = 4'd4;
  localparam logic [3:0] HDR_BYTES     = 4'd8;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  function automatic logic tag_char_ok(input logic [7:0] b);
    return ((b >= CHAR_A) && (b <= CHAR_Z)) || (b == CHAR_TWO);
  endfunction

endpackage

`default_nettype wire

[hdl/chunk_tag_locator.sv]
// Chunk tag locator: walks an IFF-style chunk stream one word per cycle unless stalled.
// A result is computed from the word in the input stage and held in the result register.
// Throughput: one word per cycle unless stalled; the input stage and result register
// decouple the channels: input stalls only when a result meets a full, stalled output.
// Reset (synchronous, rst_n low) clears the registers, the walk state and both stages.
// Depends on ctl_pkg.
`default_nettype none

module chunk_tag_locator
  import ctl_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [7:0]               in_data_byte,
  input  wire                      in_last_byte,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic                     out_found,
  output logic [31:0]              out_chunk_offset
);

  localparam int CMP_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  logic [31:0]            wanted_tag_r;
  logic [31:0]            start_offset_r;

  logic                   s1_valid_r;
  logic [7:0]             s1_data_r;
  logic                   s1_last_r;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [31:0]            window_r, window_nxt;
  logic [2:0]             count_r, count_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [31:0]            skip_r, skip_nxt;
  logic                   answered_r, answered_nxt;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [31:0]            out_offset_r;

  logic                   res_valid;
  logic                   res_found;
  logic [31:0]            res_offset;
  logic                   advance;
  logic                   tag_done;
  logic [3:0]             count_inc;
  logic [31:0]            skip_dec;
  logic [OFFSET_BITS-1:0] hdr_pos;
  logic                   past_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_tag_r   <= '0;
      start_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WANTED_TAG:   wanted_tag_r   <= cfg_wdata;
        CFG_START_OFFSET: start_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign count_inc  = {1'b0, count_r} + 4'd1;
  assign skip_dec   = skip_r - 32'd1;
  assign hdr_pos    = pos_r - OFFSET_BITS'(3);
  assign past_start = CMP_W'(pos_r) >= CMP_W'(start_offset_r);

  // Walk step for the word in the input stage.
  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    window_nxt   = window_r;
    count_nxt    = count_r;
    size_nxt     = size_r;
    skip_nxt     = skip_r;
    answered_nxt = answered_r;
    tag_done     = 1'b0;
    res_valid    = 1'b0;
    res_found    = 1'b0;
    res_offset   = '0;

    if (!answered_r) begin
      unique case (phase_r)
        PH_SEARCH: begin
          window_nxt = {window_r[23:0], s1_data_r};
          if (past_start && tag_char_ok(s1_data_r)) begin
            if (count_inc >= HDR_TAG_BYTES) begin
              count_nxt = HDR_TAG_BYTES[2:0];
              size_nxt  = '0;
              phase_nxt = PH_HEADER;
              tag_done  = 1'b1;
            end else begin
              count_nxt = count_inc[2:0];
            end
          end else begin
            count_nxt = '0;
          end
        end
        PH_HEADER: begin
          if ({1'b0, count_r} < HDR_TAG_BYTES) begin
            window_nxt = {window_r[23:0], s1_data_r};
            count_nxt  = count_inc[2:0];
            tag_done   = (count_inc == HDR_TAG_BYTES);
          end else begin
            // Size is little-endian: byte k of the size field lands at bit 8k.
            size_nxt = size_r | (32'(s1_data_r) << {count_r[1:0], 3'b000});
            if (count_inc >= HDR_BYTES) begin
              skip_nxt  = size_nxt;
              size_nxt  = '0;
              count_nxt = '0;
              phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_HEADER;
            end else begin
              count_nxt = count_inc[2:0];
            end
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            count_nxt = '0;
            phase_nxt = PH_HEADER;
          end
        end
        default: ;
      endcase

      if (tag_done && (window_nxt == wanted_tag_r)) begin
        answered_nxt = 1'b1;
        res_valid    = 1'b1;
        res_found    = 1'b1;
        res_offset   = 32'(hdr_pos);
      end
    end

    if (s1_last_r) begin
      if (!answered_nxt) begin
        res_valid = 1'b1;
      end
      // Drop all walk state so the next word starts a new stream.
      pos_nxt      = '0;
      phase_nxt    = PH_SEARCH;
      window_nxt   = '0;
      count_nxt    = '0;
      size_nxt     = '0;
      skip_nxt     = '0;
      answered_nxt = 1'b0;
    end else if (pos_r != '1) begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end
  end

  // Advance the input stage unless its result has nowhere to go.
  assign advance  = s1_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_SEARCH;
      window_r   <= '0;
      count_r    <= '0;
      size_r     <= '0;
      skip_r     <= '0;
      answered_r <= 1'b0;
    end else if (advance) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      window_r   <= window_nxt;
      count_r    <= count_nxt;
      size_r     <= size_nxt;
      skip_r     <= skip_nxt;
      answered_r <= answered_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_found_r  <= res_found;
      out_offset_r <= res_offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chunk_offset = out_offset_r;

endmodule

`default_nettype wire

[test/chunk_tag_locator_test.sv]
// Testbench for chunk_tag_locator: random chunk streams go in under burst and stall
// pressure, and every result is checked against a predictor kept in a scoreboard class.
// Depends on ctl_pkg and the chunk_tag_locator RTL.
`default_nettype none

module chunk_tag_locator_test;
  import ctl_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_WORDS   = 160;
  localparam int NUM_PHASES    = 12;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } locate_result_t;

  // Tracks one stream the way the block walks it and holds the results still owed.
  class locate_tracker;
    logic [31:0]    wanted_tag   = '0;
    logic [31:0]    start_offset = '0;
    logic [31:0]    byte_pos     = '0;
    phase_t         walk         = PH_SEARCH;
    logic [31:0]    tag_window   = '0;
    int unsigned    hdr_count    = 0;
    logic [31:0]    size_acc     = '0;
    logic [31:0]    skip_left    = '0;
    bit             answered     = 1'b0;
    locate_result_t expected_hits[$];
    int             errors       = 0;

    task report(input string what);
      if (errors < 100) $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    function void note_word(input logic [7:0] d, input logic last);
      logic [31:0] pos;
      bit          tag_done;
      pos      = byte_pos;
      tag_done = 1'b0;
      if (!answered) begin
        case (walk)
          PH_SEARCH: begin
            tag_window = {tag_window[23:0], d};
            if (pos >= start_offset && ((d >= CHAR_A && d <= CHAR_Z) || d == CHAR_TWO)) begin
              hdr_count++;
              if (hdr_count >= 4) begin
                hdr_count = 4;
                size_acc  = '0;
                walk      = PH_HEADER;
                tag_done  = 1'b1;
              end
            end else begin
              hdr_count = 0;
            end
          end
          PH_HEADER: begin
            if (hdr_count < 4) begin
              tag_window = {tag_window[23:0], d};
              hdr_count++;
              if (hdr_count == 4) tag_done = 1'b1;
            end else begin
              // size field arrives little-endian
              size_acc = size_acc | ({24'd0, d} << (8 * ((hdr_count - 4) & 3)));
              hdr_count++;
              if (hdr_count >= 8) begin
                skip_left = size_acc;
                size_acc  = '0;
                hdr_count = 0;
                walk      = (skip_left != 0) ? PH_SKIP : PH_HEADER;
              end
            end
          end
          PH_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 0) begin
              hdr_count = 0;
              walk      = PH_HEADER;
            end
          end
          default: ;
        endcase
        if (tag_done && tag_window == wanted_tag) begin
          answered = 1'b1;
          expected_hits.push_back('{found: 1'b1, offset: pos - 32'd3});
        end
      end
      if (last) begin
        if (!answered) expected_hits.push_back('{found: 1'b0, offset: 32'd0});
        // stream over: walk state back to reset, registers kept
        byte_pos   = '0;
        walk       = PH_SEARCH;
        tag_window = '0;
        hdr_count  = 0;
        size_acc   = '0;
        skip_left  = '0;
        answered   = 1'b0;
      end else if (pos != '1) begin
        byte_pos = pos + 1;
      end
    endfunction

    task check_result(input logic found, input logic [31:0] offset);
      locate_result_t want;
      if (expected_hits.size() == 0) begin
        report($sformatf("unexpected result found=%0b offset=%0d", found, offset));
      end else begin
        want = expected_hits.pop_front();
        if (found !== want.found)
          report($sformatf("found is %0b, expected %0b", found, want.found));
        if (offset !== want.offset)
          report($sformatf("chunk_offset is %0d, expected %0d", offset, want.offset));
      end
    endtask
  endclass

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     cfg_we           = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index        = CFG_WANTED_TAG;
  logic [CFG_DATA_BITS-1:0] cfg_wdata        = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_data_byte     = '0;
  logic                     in_last_byte     = 1'b0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  logic                     out_found;
  logic [31:0]              out_chunk_offset;

  locate_tracker sb = new();

  logic [7:0] stream_bytes[$];
  int         words_sent = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  chunk_tag_locator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_chunk_offset (out_chunk_offset)
  );

  always #4 clk = ~clk;

  // Receiver: stall in modes of random length (free, light, heavy, held).
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_found, out_chunk_offset);
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WANTED_TAG) sb.wanted_tag = val;
    else sb.start_offset = val;
  endtask

  task automatic send_word(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(d, last);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_word(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // Drop valid, wait out every owed result, then let the pipeline empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] tag_char();
    logic [7:0] c;
    c = ($urandom_range(0, 26) == 26) ? CHAR_TWO : CHAR_A + 8'($urandom_range(0, 25));
    return c;
  endfunction

  function automatic logic [31:0] random_tag();
    return {tag_char(), tag_char(), tag_char(), tag_char()};
  endfunction

  // Random byte that can never extend a run of tag characters.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b >= CHAR_A && b <= CHAR_Z) || b == CHAR_TWO) b[7] = 1'b1;
    return b;
  endfunction

  function automatic void add_chunk(input logic [31:0] tg, input logic [31:0] sz, input int body);
    stream_bytes.push_back(tg[31:24]);
    stream_bytes.push_back(tg[23:16]);
    stream_bytes.push_back(tg[15:8]);
    stream_bytes.push_back(tg[7:0]);
    stream_bytes.push_back(sz[7:0]);
    stream_bytes.push_back(sz[15:8]);
    stream_bytes.push_back(sz[23:16]);
    stream_bytes.push_back(sz[31:24]);
    repeat (body) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic build_stream();
    int          kind;
    int          chunks;
    int          body;
    int          lead;
    logic [31:0] sz;
    logic [31:0] tg;
    stream_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // lead-in of filler reaching the start offset when it is below 16, then a chunk walk
      lead = $urandom_range(0, 3) + ((sb.start_offset < 16) ? int'(sb.start_offset) : 0);
      repeat (lead) stream_bytes.push_back(filler_byte());
      chunks = $urandom_range(1, 4);
      for (int c = 0; c < chunks; c++) begin
        tg = ($urandom_range(0, 2) == 0) ? sb.wanted_tag : random_tag();
        case ($urandom_range(0, 9))
          0, 1:    sz = '0;
          9:       sz = $urandom;
          default: sz = $urandom_range(1, 12);
        endcase
        body = (sz > 40) ? $urandom_range(0, 6) : int'(sz);
        add_chunk(tg, sz, body);
        if (sz > 40) break;
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) if (stream_bytes.size() > 1) void'(stream_bytes.pop_back());
    end else if (kind == 7) begin
      // wanted tag buried in noise
      repeat ($urandom_range(0, 10)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      add_chunk(sb.wanted_tag, $urandom_range(0, 6), $urandom_range(0, 6));
      repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 30)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // header cut short
      tg = $urandom_range(0, 1) ? sb.wanted_tag : random_tag();
      add_chunk(tg, $urandom, 0);
      repeat ($urandom_range(1, 7)) void'(stream_bytes.pop_back());
    end
    if (stream_bytes.size() == 0) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int          goal;
    logic [31:0] tg;
    logic [31:0] offs;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: match on the last byte, zero size, bytes after a match, no valid run
    write_reg(CFG_WANTED_TAG, {CHAR_A, 8'h42, CHAR_Z, CHAR_TWO});
    write_reg(CFG_START_OFFSET, 32'd0);
    stream_bytes = '{CHAR_A, 8'h42, CHAR_Z, CHAR_TWO};
    send_stream();
    stream_bytes = '{8'h40, 8'h5B, 8'h31, 8'h33, 8'h58, 8'h59, CHAR_Z, 8'h57,
                     8'h00, 8'h00, 8'h00, 8'h00, CHAR_A, 8'h42, CHAR_Z, CHAR_TWO,
                     8'hFF, 8'h00};
    send_stream();
    stream_bytes = '{8'h51, 8'h51};
    send_stream();
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin tg = random_tag();   offs = 32'd0;          end
        1:       begin tg = 32'hFFFF_FFFF;  offs = 32'd0;          end
        2:       begin tg = 32'd0;          offs = 32'd2;          end
        3:       begin tg = random_tag();   offs = 32'hFFFF_FFFF;  end
        4:       begin tg = random_tag();   offs = 32'd1;          end
        default: begin
          tg   = ($urandom_range(0, 9) == 0) ? $urandom : random_tag();
          offs = $urandom_range(0, 12);
        end
      endcase
      write_reg(CFG_WANTED_TAG, tg);
      write_reg(CFG_START_OFFSET, offs);
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        build_stream();
        send_stream();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_hits.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_hits.size()));
    if (sb.errors == 0) begin
      $display("chunk_tag_locator: match");
    end else begin
      $display("chunk_tag_locator: mismatch");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("chunk_tag_locator: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
